FILE: rtl/mkrc_pkg.sv
// Shared constants and types for the address-keyed result cache.
`default_nettype none
package mkrc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W     = 48;
   localparam int LOW_W      = 64;
   localparam int HIGH_W     = 56;
   localparam int CONF_W     = 16;
   localparam int TIME_W     = 32;
   localparam int FILL_W     = 5;
   localparam int TEXT_BYTES = 15;
   localparam int TEXT_W     = LOW_W + HIGH_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              is_write;
      logic              is_lookup;
      logic [ADDR_W-1:0] key;
      logic [LOW_W-1:0]  text_low;
      logic [HIGH_W-1:0] text_high;
      logic [CONF_W-1:0] conf;
      logic [TIME_W-1:0] stamp;
      logic [IDX_W-1:0]  target;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [LOW_W-1:0]  found_low;
      logic [HIGH_W-1:0] found_high;
      logic [CONF_W-1:0] found_conf;
      logic [TIME_W-1:0] found_time;
      logic              has_empty;
      logic [IDX_W-1:0]  empty_idx;
      logic              has_old;
      logic [IDX_W-1:0]  old_idx;
      logic [TIME_W-1:0] old_time;
   } probe_type;

   typedef struct packed {
      logic              hit;
      logic              written;
      logic [LOW_W-1:0]  found_low;
      logic [HIGH_W-1:0] found_high;
      logic [CONF_W-1:0] found_conf;
      logic [TIME_W-1:0] found_time;
      logic [FILL_W-1:0] filled_count;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/mkrc_if.sv
// Request and response channel interfaces of the result cache.
`default_nettype none
interface mkrc_req_if import mkrc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] device_address;
   logic [LOW_W-1:0]  type_text_low;
   logic [HIGH_W-1:0] type_text_high;
   logic [CONF_W-1:0] confidence;
   logic [TIME_W-1:0] now_ms;

   modport source (
      output valid, action, device_address, type_text_low, type_text_high, confidence,
             now_ms,
      input  ready
   );
   modport sink (
      input  valid, action, device_address, type_text_low, type_text_high, confidence,
             now_ms,
      output ready
   );
endinterface

interface mkrc_rsp_if import mkrc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              hit;
   logic              written;
   logic [LOW_W-1:0]  found_type_low;
   logic [HIGH_W-1:0] found_type_high;
   logic [CONF_W-1:0] found_confidence;
   logic [TIME_W-1:0] found_time_ms;
   logic [FILL_W-1:0] filled_count;

   modport source (
      output valid, hit, written, found_type_low, found_type_high, found_confidence,
             found_time_ms, filled_count,
      input  ready
   );
   modport sink (
      input  valid, hit, written, found_type_low, found_type_high, found_confidence,
             found_time_ms, filled_count,
      output ready
   );
endinterface
`default_nettype wire

FILE: rtl/mkrc_cell.sv
// One table entry: holds its record and updates the probe passing through.
`default_nettype none
module mkrc_cell import mkrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  probe_type        up_probe,
   output probe_type        dn_probe
);

   logic              valid_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LOW_W-1:0]  low_ff;
   logic [HIGH_W-1:0] high_ff;
   logic [CONF_W-1:0] conf_ff;
   logic [TIME_W-1:0] time_ff;
   probe_type         probe_ff;
   probe_type         probe_in;
   logic              write_en;

   always_comb begin
      probe_in = up_probe;
      write_en = up_probe.valid && up_probe.is_write && (up_probe.target == cell_index);
      if (up_probe.valid && !up_probe.is_write) begin
         if (valid_ff && (addr_ff == up_probe.key) && !up_probe.hit) begin
            probe_in.hit        = 1'b1;
            probe_in.hit_idx    = cell_index;
            probe_in.found_low  = low_ff;
            probe_in.found_high = high_ff;
            probe_in.found_conf = conf_ff;
            probe_in.found_time = time_ff;
         end
         if (!valid_ff && !up_probe.has_empty) begin
            probe_in.has_empty = 1'b1;
            probe_in.empty_idx = cell_index;
         end
         if (valid_ff && (time_ff < up_probe.old_time)) begin
            probe_in.has_old  = 1'b1;
            probe_in.old_idx  = cell_index;
            probe_in.old_time = time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff <= probe_in;
         if (write_en) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         addr_ff <= up_probe.key;
         low_ff  <= up_probe.text_low;
         high_ff <= up_probe.text_high;
         conf_ff <= up_probe.conf;
         time_ff <= up_probe.stamp;
      end
   end

   assign dn_probe = probe_ff;

endmodule
`default_nettype wire

FILE: rtl/mkrc_ctrl.sv
// Sequencer: launches search and write probes, decides the slot, holds the response.
`default_nettype none
module mkrc_ctrl import mkrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mkrc_req_if.sink   req,
   mkrc_rsp_if.source rsp,
   output probe_type  launch,
   input  probe_type  tail
);

   state_type        state_ff, state_in;
   probe_type        launch_ff, launch_in;
   logic [CNT_W-1:0] count_ff, count_in;
   result_type       pend_ff, pend_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             do_write;
   logic [IDX_W-1:0] write_idx;
   logic [TEXT_W-1:0] clipped;

   function automatic logic [TEXT_W-1:0] clip_text(input logic [TEXT_W-1:0] text);
      logic              ended;
      logic [TEXT_W-1:0] res;
      ended = 1'b0;
      res   = text;
      for (int b = 0; b < TEXT_BYTES; b++) begin
         if (ended) begin
            res[b*8 +: 8] = 8'h00;
         end else if (text[b*8 +: 8] == 8'h00) begin
            ended = 1'b1;
         end
      end
      return res;
   endfunction

   assign clipped = clip_text({req.type_text_high, req.type_text_low});

   always_comb begin
      state_in        = state_ff;
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      count_in        = count_ff;
      pend_in         = pend_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      do_write        = 1'b0;
      write_idx       = tail.hit_idx;
      req.ready       = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               launch_in            = '0;
               launch_in.valid      = 1'b1;
               launch_in.is_lookup  = req.action;
               launch_in.key        = req.device_address;
               launch_in.text_low   = clipped[LOW_W-1:0];
               launch_in.text_high  = clipped[TEXT_W-1:LOW_W];
               launch_in.conf       = req.confidence;
               launch_in.stamp      = req.now_ms;
               launch_in.old_time   = '1;
               state_in             = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tail.valid && !tail.is_write) begin
               pend_in = '0;
               priority if (tail.is_lookup) begin
                  pend_in.hit = tail.hit;
                  if (tail.hit) begin
                     pend_in.found_low  = tail.found_low;
                     pend_in.found_high = tail.found_high;
                     pend_in.found_conf = tail.found_conf;
                     pend_in.found_time = tail.found_time;
                  end
               end else if (tail.hit) begin
                  do_write        = 1'b1;
                  write_idx       = tail.hit_idx;
                  pend_in.hit     = 1'b1;
                  pend_in.written = 1'b1;
               end else if (tail.has_empty || tail.has_old) begin
                  do_write        = 1'b1;
                  write_idx       = tail.has_empty ? tail.empty_idx : tail.old_idx;
                  pend_in.written = 1'b1;
                  if (count_ff != CNT_W'(TABLE_ENTRIES)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  pend_in.written = 1'b0;
               end
               pend_in.filled_count = FILL_W'(count_in);
               if (do_write) begin
                  launch_in          = tail;
                  launch_in.valid    = 1'b1;
                  launch_in.is_write = 1'b1;
                  launch_in.target   = write_idx;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         launch_ff.valid <= 1'b0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign launch               = launch_ff;
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.hit              = rsp_ff.hit;
   assign rsp.written          = rsp_ff.written;
   assign rsp.found_type_low   = rsp_ff.found_low;
   assign rsp.found_type_high  = rsp_ff.found_high;
   assign rsp.found_confidence = rsp_ff.found_conf;
   assign rsp.found_time_ms    = rsp_ff.found_time;
   assign rsp.filled_count     = rsp_ff.filled_count;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("fill count above table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("fill count moved by more than one");

   a_write_from_search: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && launch_ff.valid && launch_ff.is_write |-> $past(state_ff == ST_SEARCH))
      else $error("write probe launched outside search");

   a_accept_launch: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> launch_ff.valid && !launch_ff.is_write)
      else $error("accepted transaction did not launch a search probe");

endmodule
`default_nettype wire

FILE: rtl/mac_keyed_result_cache.sv
// A search probe passes the launch register, each entry cell's probe register, the pending
// and the response register, walking the entry cells one cell per cycle; a store's write
// probe trails it. The next transaction is taken once the response is registered.
// The response register frees the request side while a response waits to be taken.
// Reset clears all entry valid bits and the fill count directly; no clearing pass.
`default_nettype none
module mac_keyed_result_cache import mkrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mkrc_req_if.sink   req_chan,
   mkrc_rsp_if.source rsp_chan
);

   probe_type chain [TABLE_ENTRIES+1];

   mkrc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .rsp    (rsp_chan),
      .launch (chain[0]),
      .tail   (chain[TABLE_ENTRIES])
   );

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      mkrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .up_probe   (chain[i]),
         .dn_probe   (chain[i+1])
      );
   end

endmodule
`default_nettype wire
